// ----- sv/greedy_box_suppression_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the greedy box suppression core
// Short forms for clocked implication checks with async reset disable.
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_CORE_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_CORE_MACROS_SVH

// same-cycle implication
`define GBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/gbs_pkg.sv -----
// ----------------------------------------------------------------------------
// gbs_pkg
// Types and fixed widths shared by the box suppression core and its channels.
// ----------------------------------------------------------------------------
`default_nettype none

package gbs_pkg;

	localparam int COORD_W  = 12;
	localparam int SPAN_W   = 11;
	localparam int AREA_W   = 22;
	localparam int UNI_W    = 23;
	localparam int THR_W    = 9;
	localparam int PROD_W   = THR_W + UNI_W;
	localparam int IDX_W    = 15;
	localparam int TOTAL_W  = 7;
	localparam int FRAC_SH  = 8;

	localparam logic [THR_W-1:0] THR_RESET = 9'd115;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SPAN_W-1:0]         w;
		logic [SPAN_W-1:0]         h;
	} box_t;

	typedef struct packed {
		box_t              box;
		logic [AREA_W-1:0] area;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ----- sv/gbs_ifs.sv -----
// ----------------------------------------------------------------------------
// gbs channel interfaces
// Valid/ready channels for input boxes and suppression results.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbs_box_if;
	logic                               valid;
	logic                               ready;
	logic signed [gbs_pkg::COORD_W-1:0] box_x;
	logic signed [gbs_pkg::COORD_W-1:0] box_y;
	logic [gbs_pkg::SPAN_W-1:0]         box_w;
	logic [gbs_pkg::SPAN_W-1:0]         box_h;
	logic                               first_in_set;

	modport source (output valid, box_x, box_y, box_w, box_h, first_in_set, input ready);
	modport sink (input valid, box_x, box_y, box_w, box_h, first_in_set, output ready);
endinterface

interface gbs_res_if;
	logic                         valid;
	logic                         ready;
	logic                         keep;
	logic [gbs_pkg::IDX_W-1:0]    box_index;
	logic                         stored;
	logic [gbs_pkg::TOTAL_W-1:0]  kept_total;

	modport source (output valid, keep, box_index, stored, kept_total, input ready);
	modport sink (input valid, keep, box_index, stored, kept_total, output ready);
endinterface

`default_nettype wire

// ----- sv/greedy_box_suppression_core.sv -----
// ----------------------------------------------------------------------------
// greedy_box_suppression_core
// Greedy IoU non-maximum suppression over a table of kept boxes.
// ----------------------------------------------------------------------------
// Boxes come in one beat at a time in falling confidence order. Each box is
// checked against every kept box, one table entry per cycle out of a single
// RAM read port, through a five-stage overlap pipeline (clip, intersect
// multiply, union, threshold multiply, compare). A box that is not suppressed
// is written to the table while there is room. The next box is taken only
// once the result of the previous one is loaded into the result register.
// A result that still waits at the output when the next one is ready holds
// the core until it is taken. A new box is taken while the previous result
// still waits at the output. first_in_set empties the table and restarts
// the box index. The threshold register may only be written while no box
// is in flight.
`default_nettype none

`include "greedy_box_suppression_core_macros.svh"

module greedy_box_suppression_core #(
	parameter int MAX_KEPT  = 64,
	parameter int MAX_BOXES = 32768
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [gbs_pkg::THR_W-1:0]  cfg_wdata,
	gbs_box_if.sink                         in_box,
	gbs_res_if.source                       out_res
);

	import gbs_pkg::*;

	localparam int AW     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CNT_W  = $clog2(MAX_KEPT + 1);
	localparam int SIDX_W = $clog2(MAX_BOXES);
	localparam int ENT_W  = $bits(entry_t);
	localparam logic [CNT_W-1:0]  KEPT_MAX  = CNT_W'(MAX_KEPT);
	localparam logic [SIDX_W-1:0] SIDX_LAST = SIDX_W'(MAX_BOXES - 1);

	state_t state_q, state_d;

	logic [THR_W-1:0]  thr_q;
	box_t              box_q;
	logic [AREA_W-1:0] area_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_q;
	logic [SIDX_W-1:0] set_idx_q;
	logic [SIDX_W-1:0] idx_q;
	logic              hit_q;

	logic in_acc;
	logic rd_en;
	logic done_load;
	logic ram_we;
	logic busy;

	logic [SIDX_W-1:0] idx_base;

	entry_t     rd_ent;
	logic [ENT_W-1:0] rdata;
	entry_t     wr_ent;

	// overlap pipeline
	logic                rv_s1;
	logic                v_s2, v_s3, v_s4, v_s5;
	logic [SPAN_W-1:0]   dx_s2, dy_s2;
	logic [AREA_W-1:0]   karea_s2, karea_s3;
	logic [AREA_W-1:0]   inter_s3, inter_s4, inter_s5;
	logic [UNI_W-1:0]    uni_s4;
	logic [PROD_W-1:0]   prod_s5;

	logic signed [COORD_W:0] ax0, ax1, bx0, bx1, ay0, ay1, by0, by1;
	logic signed [COORD_W:0] x0, x1, y0, y1, dxs, dys;
	logic [SPAN_W-1:0]       dx_c, dy_c;

	logic              out_valid_q;
	logic              out_keep_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_stored_q;
	logic [TOTAL_W-1:0] out_total_q;

	// ------------------------------------------------------------------
	// control
	// ------------------------------------------------------------------
	assign busy = rv_s1 | v_s2 | v_s3 | v_s4 | v_s5;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_box.valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (rd_q == count_q && !busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_res.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_box.ready = (state_q == ST_IDLE);
		rd_en        = (state_q == ST_SCAN) && (rd_q < count_q);
		done_load    = (state_q == ST_DONE) && (!out_valid_q || out_res.ready);
		ram_we       = done_load && !hit_q && (count_q < KEPT_MAX);
	end

	assign in_acc   = in_box.valid && in_box.ready;
	assign idx_base = in_box.first_in_set ? '0 : set_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			thr_q     <= THR_RESET;
			count_q   <= '0;
			set_idx_q <= '0;
			rd_q      <= '0;
			hit_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) thr_q <= cfg_wdata;
			if (in_acc) begin
				set_idx_q <= (idx_base == SIDX_LAST) ? '0 : idx_base + 1'b1;
				rd_q      <= '0;
				hit_q     <= 1'b0;
				if (in_box.first_in_set) count_q <= '0;
			end else begin
				if (rd_en) rd_q <= rd_q + 1'b1;
				if (v_s5 && ({2'b00, inter_s5, FRAC_SH'(0)} > prod_s5)) hit_q <= 1'b1;
				if (ram_we) count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			box_q.x <= in_box.box_x;
			box_q.y <= in_box.box_y;
			box_q.w <= in_box.box_w;
			box_q.h <= in_box.box_h;
			idx_q   <= idx_base;
		end
		area_q <= box_q.w * box_q.h;
	end

	// ------------------------------------------------------------------
	// kept table
	// ------------------------------------------------------------------
	assign wr_ent.box  = box_q;
	assign wr_ent.area = area_q;
	assign rd_ent      = entry_t'(rdata);

	gbs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_KEPT)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (wr_ent),
		.re    (rd_en),
		.raddr (rd_q[AW-1:0]),
		.rdata (rdata)
	);

	// ------------------------------------------------------------------
	// overlap pipeline
	// ------------------------------------------------------------------
	always_comb begin
		ax0 = (COORD_W+1)'(box_q.x);
		ay0 = (COORD_W+1)'(box_q.y);
		bx0 = (COORD_W+1)'(rd_ent.box.x);
		by0 = (COORD_W+1)'(rd_ent.box.y);
		ax1 = ax0 + $signed({2'b00, box_q.w});
		ay1 = ay0 + $signed({2'b00, box_q.h});
		bx1 = bx0 + $signed({2'b00, rd_ent.box.w});
		by1 = by0 + $signed({2'b00, rd_ent.box.h});
		x0  = (ax0 > bx0) ? ax0 : bx0;
		y0  = (ay0 > by0) ? ay0 : by0;
		x1  = (ax1 < bx1) ? ax1 : bx1;
		y1  = (ay1 < by1) ? ay1 : by1;
		// positive span never exceeds either box width
		dxs = x1 - x0;
		dys = y1 - y0;
		dx_c = (dxs > 0) ? dxs[SPAN_W-1:0] : '0;
		dy_c = (dys > 0) ? dys[SPAN_W-1:0] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
		end else begin
			rv_s1 <= rd_en;
			v_s2  <= rv_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s2    <= dx_c;
		dy_s2    <= dy_c;
		karea_s2 <= rd_ent.area;
		inter_s3 <= dx_s2 * dy_s2;
		karea_s3 <= karea_s2;
		// intersection is at most the smaller area, so union never goes negative
		uni_s4   <= UNI_W'(area_q) + UNI_W'(karea_s3) - UNI_W'(inter_s3);
		inter_s4 <= inter_s3;
		prod_s5  <= thr_q * uni_s4;
		inter_s5 <= inter_s4;
	end

	// ------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_load) begin
			out_valid_q <= 1'b1;
		end else if (out_res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_load) begin
			out_keep_q   <= !hit_q;
			out_idx_q    <= IDX_W'(idx_q);
			out_stored_q <= ram_we;
			out_total_q  <= TOTAL_W'(count_q + CNT_W'(ram_we));
		end
	end

	assign out_res.valid      = out_valid_q;
	assign out_res.keep       = out_keep_q;
	assign out_res.box_index  = out_idx_q;
	assign out_res.stored     = out_stored_q;
	assign out_res.kept_total = out_total_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	`GBS_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= KEPT_MAX, "kept count past table size")
	`GBS_ASSERT_IMPL(a_read_below_count, clk, arst_n, rd_en, rd_q < count_q, "table read beyond kept entries")
	`GBS_ASSERT_IMPL(a_write_only_kept, clk, arst_n, ram_we, !hit_q && !busy, "table write for suppressed box or during scan")
	`GBS_ASSERT_NEXT(a_stored_means_keep, clk, arst_n, done_load && ram_we, out_res.valid && out_res.keep && out_res.stored, "stored beat not reported as kept")

endmodule

`default_nettype wire

// ----- sv/gbs_ram.sv -----
// ----------------------------------------------------------------------------
// gbs_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                           clk,
	input  wire logic                                           we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
	input  wire logic [WIDTH-1:0]                               wdata,
	input  wire logic                                           re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
	output logic [WIDTH-1:0]                                    rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
